@@ hw/rtl/ads_pkg.sv @@
// Shared types and constants for the alarm display sequencer.
// No dependencies; used by every module of the block.
package ads_pkg;

	// Sequencer state, one-hot
	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_HOLD  = 5'b00010,
		PH_BONUS = 5'b00100,
		PH_INT   = 5'b01000,
		PH_DEACT = 5'b10000
	} phase_t;

	// Phase codes as reported on the result
	localparam logic [2:0] PHC_IDLE  = 3'd0;
	localparam logic [2:0] PHC_HOLD  = 3'd1;
	localparam logic [2:0] PHC_BONUS = 3'd2;
	localparam logic [2:0] PHC_INT   = 3'd3;
	localparam logic [2:0] PHC_DEACT = 3'd4;

	// Panel visibility commands
	localparam logic [1:0] VIS_KEEP = 2'd0;
	localparam logic [1:0] VIS_HIDE = 2'd1;
	localparam logic [1:0] VIS_SHOW = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_HOLD_TIME    = 2'd0;
	localparam logic [1:0] REG_BONUS_TIME   = 2'd1;
	localparam logic [1:0] REG_AUTO_TIMEOUT = 2'd2;
	localparam logic [1:0] REG_NOTIFY_LEVEL = 2'd3;

	// Register reset values
	localparam logic [31:0] HOLD_TIME_RST    = 32'd2000;
	localparam logic [31:0] BONUS_TIME_RST   = 32'd1000;
	localparam logic [31:0] AUTO_TIMEOUT_RST = 32'd10000;
	localparam logic [7:0]  NOTIFY_LEVEL_RST = 8'd0;

	localparam int IN_BITS  = 44;
	localparam int IN_BYTES = 6;
	localparam int OUT_BITS = 8;

	typedef struct packed {
		logic [31:0] hold_time;
		logic [31:0] bonus_time;
		logic [31:0] auto_timeout;
		logic [7:0]  notify_level;
	} cfg_t;

	// Input item, last field in the lowest bits
	typedef struct packed {
		logic        dismiss;
		logic        shown_on;
		logic        head_is_data;
		logic [7:0]  head_priority;
		logic        head_valid;
		logic [31:0] now_time;
	} in_item_t;

	// Result item, last field in the lowest bits
	typedef struct packed {
		logic [2:0] phase;
		logic       deactivate;
		logic       drop_current;
		logic [1:0] visibility;
		logic       pop_head;
	} res_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		code = PHC_IDLE;
		unique case (ph)
			PH_HOLD:  code = PHC_HOLD;
			PH_BONUS: code = PHC_BONUS;
			PH_INT:   code = PHC_INT;
			PH_DEACT: code = PHC_DEACT;
			default:  code = PHC_IDLE;
		endcase
		return code;
	endfunction

endpackage

@@ hw/rtl/ads_cfg.sv @@
// Configuration register file of the alarm display sequencer.
// Depends on ads_pkg for register indexes, reset values and cfg_t.
module ads_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [31:0]       wr_data,
	output ads_pkg::cfg_t     cfg
);

	ads_pkg::cfg_t cfg_q;

	// Register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time    <= ads_pkg::HOLD_TIME_RST;
			cfg_q.bonus_time   <= ads_pkg::BONUS_TIME_RST;
			cfg_q.auto_timeout <= ads_pkg::AUTO_TIMEOUT_RST;
			cfg_q.notify_level <= ads_pkg::NOTIFY_LEVEL_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				ads_pkg::REG_HOLD_TIME:    cfg_q.hold_time    <= wr_data;
				ads_pkg::REG_BONUS_TIME:   cfg_q.bonus_time   <= wr_data;
				ads_pkg::REG_AUTO_TIMEOUT: cfg_q.auto_timeout <= wr_data;
				ads_pkg::REG_NOTIFY_LEVEL: cfg_q.notify_level <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/ads_seq.sv @@
// Five-phase sequencer: state registers and the per-tick decision logic.
// Depends on ads_pkg for phase_t, in_item_t, res_t and cfg_t.
module ads_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  ads_pkg::in_item_t    item,
	input  ads_pkg::cfg_t        cfg,
	output ads_pkg::res_t        res
);

	ads_pkg::phase_t state_q, state_nxt;
	logic [31:0]     start_time_q;
	logic [7:0]      cur_priority_q;
	logic            cur_is_data_q;

	logic [31:0] elapsed;
	logic [32:0] bonus_end;
	logic        pop;
	logic [1:0]  vis;
	logic        drop;
	logic        deact;

	// Wrapping elapsed time; bonus window end kept at 33 bits
	assign elapsed   = item.now_time - start_time_q;
	assign bonus_end = {1'b0, cfg.hold_time} + {1'b0, cfg.bonus_time};

	// Decision logic for one tick
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		vis       = ads_pkg::VIS_KEEP;
		drop      = 1'b0;
		deact     = 1'b0;
		unique case (state_q)
			ads_pkg::PH_HOLD: begin
				if (item.dismiss) begin
					state_nxt = ads_pkg::PH_DEACT;
				end else if (elapsed < cfg.hold_time) begin
					if (item.shown_on || cur_priority_q == cfg.notify_level) begin
						vis = ads_pkg::VIS_SHOW;
					end else begin
						drop      = cur_is_data_q;
						state_nxt = ads_pkg::PH_IDLE;
					end
				end else if (!item.head_valid) begin
					state_nxt = ads_pkg::PH_INT;
				end else if (item.head_priority <= cur_priority_q) begin
					drop      = cur_is_data_q;
					state_nxt = ads_pkg::PH_IDLE;
				end else begin
					state_nxt = ads_pkg::PH_BONUS;
				end
			end
			ads_pkg::PH_BONUS: begin
				if (item.dismiss) begin
					state_nxt = ads_pkg::PH_DEACT;
				end else if ({1'b0, elapsed} < bonus_end) begin
					if (item.shown_on) begin
						vis = ads_pkg::VIS_SHOW;
					end else begin
						drop      = cur_is_data_q;
						state_nxt = ads_pkg::PH_IDLE;
					end
				end else begin
					// window over by time: back to idle, no drop
					state_nxt = ads_pkg::PH_IDLE;
				end
			end
			ads_pkg::PH_INT: begin
				if (item.dismiss || elapsed >= cfg.auto_timeout) begin
					state_nxt = ads_pkg::PH_DEACT;
				end else if (item.shown_on) begin
					vis = ads_pkg::VIS_SHOW;
				end else begin
					drop      = cur_is_data_q;
					state_nxt = ads_pkg::PH_IDLE;
				end
			end
			ads_pkg::PH_DEACT: begin
				deact     = 1'b1;
				state_nxt = ads_pkg::PH_IDLE;
			end
			default: begin
				// idle: hide the panel, take the head if present
				vis       = ads_pkg::VIS_HIDE;
				state_nxt = ads_pkg::PH_IDLE;
				if (item.head_valid) begin
					pop       = 1'b1;
					state_nxt = ads_pkg::PH_HOLD;
				end
			end
		endcase
	end

	// State update, once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ads_pkg::PH_IDLE;
			start_time_q   <= '0;
			cur_priority_q <= '0;
			cur_is_data_q  <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
			if (pop) begin
				start_time_q   <= item.now_time;
				cur_priority_q <= item.head_priority;
				cur_is_data_q  <= item.head_is_data;
			end
		end
	end

	assign res.pop_head     = pop;
	assign res.visibility   = vis;
	assign res.drop_current = drop;
	assign res.deactivate   = deact;
	assign res.phase        = ads_pkg::phase_code(state_nxt);

endmodule

@@ hw/rtl/alarm_display_sequencer_top.sv @@
// A tick accepted into the input register is evaluated when stage 1 advances,
// which loads its result onto m_axis_tdata. Throughput: one tick per cycle unless
// m_axis_tready stalls, set by the single input register and result register.
// Reset: arst_n clears the sequencer to idle, the registers to their defaults
// (hold 2000, bonus 1000, timeout 10000, notify level 0) and both stages to empty.
// Top level of the alarm display sequencer; uses ads_pkg, ads_cfg and ads_seq.
module alarm_display_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	// tick stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] now_time, [32] head_valid, [40:33] head_priority,
	// [41] head_is_data, [42] shown_on, [43] dismiss, [47:44] zero
	input  logic [47:0] s_axis_tdata,
	// command stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] pop_head, [2:1] visibility, [3] drop_current, [4] deactivate, [7:5] phase
	output logic [7:0]  m_axis_tdata,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ads_pkg::cfg_t     cfg;
	ads_pkg::in_item_t item_s1;
	ads_pkg::res_t     res;
	logic              valid_s1;
	logic              adv;
	logic              out_valid_q;
	ads_pkg::res_t     out_data_q;

	assign cfg_ready = 1'b1;

	ads_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage 1 advances when the result register is free or being drained
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= s_axis_tdata[ads_pkg::IN_BITS-1:0];
		end
	end

	ads_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

@@ hw/rtl/ads_checker.sv @@
// Port-level checks for the alarm display sequencer, bound to the top level.
// Depends on ads_pkg for phase and visibility codes.
module ads_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// A stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Taking the queue head hides the panel and enters hold
	a_pop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |->
		m_axis_tdata[2:1] == ads_pkg::VIS_HIDE && m_axis_tdata[7:5] == ads_pkg::PHC_HOLD)
		else $error("pop without hide and hold");

	// Deactivation returns to idle and leaves the panel alone
	a_deact_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[4] |->
		m_axis_tdata[2:1] == ads_pkg::VIS_KEEP && m_axis_tdata[7:5] == ads_pkg::PHC_IDLE
		&& !m_axis_tdata[0] && !m_axis_tdata[3])
		else $error("deactivate with other commands");

	// Drop always ends the shown alarm
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |->
		m_axis_tdata[7:5] == ads_pkg::PHC_IDLE && m_axis_tdata[2:1] == ads_pkg::VIS_KEEP)
		else $error("drop without return to idle");

	// Panel shown only while an alarm is held
	a_show_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:1] == ads_pkg::VIS_SHOW |->
		m_axis_tdata[7:5] == ads_pkg::PHC_HOLD || m_axis_tdata[7:5] == ads_pkg::PHC_BONUS
		|| m_axis_tdata[7:5] == ads_pkg::PHC_INT)
		else $error("show outside a holding phase");

endmodule

bind alarm_display_sequencer_top ads_checker u_ads_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
